[rtl/core/playfair_6x6_stream_cipher_defines.svh]
// assertion macros shared by the playfair 6x6 rtl
`ifndef PLAYFAIR_6X6_STREAM_CIPHER_DEFINES_SVH
`define PLAYFAIR_6X6_STREAM_CIPHER_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define PF6_ASSERT_NOW(label, clk, rst, trig, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define PF6_ASSERT_NEXT(label, clk, rst, trig, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
      else $error(msg);

`endif

[rtl/core/pf6_pkg.sv]
// shared types, constants and helper functions for the playfair 6x6 cipher
`timescale 1ns / 1ps

package pf6_pkg;

   localparam int SQ_DIM      = 6;
   localparam int BYTE_W      = 8;
   localparam int ROW_W       = SQ_DIM * BYTE_W;
   localparam int CSR_INDEX_W = 3;
   localparam int POS_W       = $clog2(SQ_DIM);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DECRYPT_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SQUARE_ROW_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SQUARE_ROW_5 = 3'd6;

   // item kinds
   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [BYTE_W-1:0] CHAR_X = 8'h58;
   localparam logic [BYTE_W-1:0] CHAR_Q = 8'h51;

   typedef logic [SQ_DIM-1:0][SQ_DIM-1:0][BYTE_W-1:0] square_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] text_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } rsp_item_type;

   function automatic logic is_digit_or_upper(input logic [BYTE_W-1:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a);
   endfunction

   function automatic logic is_alnum(input logic [BYTE_W-1:0] b);
      return is_digit_or_upper(b) || (b >= 8'h61 && b <= 8'h7a);
   endfunction

   function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] b);
      return (b >= 8'h61 && b <= 8'h7a) ? (b - 8'h20) : b;
   endfunction

   function automatic logic [BYTE_W-1:0] pad_for(input logic [BYTE_W-1:0] b);
      return (b == CHAR_X) ? CHAR_Q : CHAR_X;
   endfunction

endpackage

[rtl/core/pf6_pair_unit.sv]
// playfair pair substitution: square lookup of both letters and the three rules
`timescale 1ns / 1ps

module pf6_pair_unit
   import pf6_pkg::*;
(
   input  square_type        square,
   input  logic              decrypt,
   input  logic [BYTE_W-1:0] first_letter,
   input  logic [BYTE_W-1:0] second_letter,
   output logic [BYTE_W-1:0] first_out,
   output logic [BYTE_W-1:0] second_out
);

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } loc_type;

   // first match in row-major order wins, so scan backwards
   function automatic loc_type locate(input square_type sq, input logic [BYTE_W-1:0] ch);
      loc_type loc;
      loc = '0;
      for (int r = SQ_DIM - 1; r >= 0; r--) begin
         for (int c = SQ_DIM - 1; c >= 0; c--) begin
            if (sq[r][c] == ch) begin
               loc.found = 1'b1;
               loc.row   = POS_W'(r);
               loc.col   = POS_W'(c);
            end
         end
      end
      return loc;
   endfunction

   // one step around the square, forward or backward
   function automatic logic [POS_W-1:0] step6(input logic [POS_W-1:0] v, input logic back);
      logic [POS_W-1:0] res;
      if (back) begin
         res = (v == '0) ? POS_W'(SQ_DIM - 1) : v - 1'b1;
      end else begin
         res = (v == POS_W'(SQ_DIM - 1)) ? '0 : v + 1'b1;
      end
      return res;
   endfunction

   loc_type loc_a;
   loc_type loc_b;

   assign loc_a = locate(square, first_letter);
   assign loc_b = locate(square, second_letter);

   always_comb begin
      if (!loc_a.found || !loc_b.found) begin
         first_out  = first_letter;
         second_out = second_letter;
      end else if (loc_a.row == loc_b.row) begin
         first_out  = square[loc_a.row][step6(loc_a.col, decrypt)];
         second_out = square[loc_b.row][step6(loc_b.col, decrypt)];
      end else if (loc_a.col == loc_b.col) begin
         first_out  = square[step6(loc_a.row, decrypt)][loc_a.col];
         second_out = square[step6(loc_b.row, decrypt)][loc_b.col];
      end else begin
         first_out  = square[loc_a.row][loc_b.col];
         second_out = square[loc_b.row][loc_a.col];
      end
   end

endmodule

[rtl/core/playfair_6x6_stream_cipher.sv]
// top level of the format-preserving 6x6 playfair stream cipher
`timescale 1ns / 1ps
`include "playfair_6x6_stream_cipher_defines.svh"

// Playfair over a 6x6 square of A-Z and 0-9, one byte per input item. Letters
// and digits are upper-cased and paired; any other byte flushes a waiting
// letter and passes through. An end-of-text item flushes the waiting letter.
// Software loads the six square rows (column 0 in the low byte) and the mode
// through the csr port while the block is idle; csr writes are always taken.
// An accepted item waits in an input register until the result buffer is free;
// its 0 to 3 result bytes are then worked out and loaded into a 3-byte result
// buffer, which drains one byte per cycle on the rsp channel while rsp_ready is
// high. The block takes one item per cycle while items yield at most one result
// each and rsp_ready stays high; an item with more results (3 for a flush
// followed by a passed-through byte) holds the next item in the input register
// until its last byte leaves.
module playfair_6x6_stream_cipher
   import pf6_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_item_type           req_item,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_item_type           rsp_item,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]       csr_data
);

   // configuration
   logic       decrypt_ff, decrypt_in;
   square_type square_ff, square_in;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;

   // waiting letter
   logic              held_valid_ff, held_valid_in;
   logic [BYTE_W-1:0] held_letter_ff, held_letter_in;

   // result buffer: bytes, count still to send, read position
   logic [2:0][BYTE_W-1:0] rb_byte_ff, rb_byte_in;
   logic [1:0]             rb_left_ff, rb_left_in;
   logic [1:0]             rb_pos_ff, rb_pos_in;

   logic                   rb_free;
   logic                   advance;
   logic                   is_letter;
   logic                   is_end;
   logic                   doubled;
   logic [BYTE_W-1:0]      up_byte;
   logic [BYTE_W-1:0]      pair_second;
   logic [BYTE_W-1:0]      pair_out0;
   logic [BYTE_W-1:0]      pair_out1;
   logic [2:0][BYTE_W-1:0] res_byte;
   logic [1:0]             res_count;

   // register writes, taken every cycle
   assign csr_ready = 1'b1;

   always_comb begin
      decrypt_in = decrypt_ff;
      square_in  = square_ff;
      if (csr_valid) begin
         unique case (csr_index) inside
            CSR_DECRYPT_MODE: decrypt_in = csr_data[0];
            [CSR_SQUARE_ROW_0:CSR_SQUARE_ROW_5]:
               square_in[POS_W'(csr_index - CSR_SQUARE_ROW_0)] = csr_data;
            default: ;
         endcase
      end
   end

   // the buffer can take a new item when empty or when its last byte leaves now
   assign rb_free   = (rb_left_ff == 2'd0) || (rb_left_ff == 2'd1 && rsp_ready);
   assign advance   = in_valid_ff && rb_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_item_in  = req_item;
      end
   end

   // item decode
   assign is_end    = (in_item_ff.kind == KIND_END);
   assign up_byte   = upcase(in_item_ff.text_byte);
   assign is_letter = !is_end && is_alnum(in_item_ff.text_byte);
   // encrypt mode pads a doubled letter and keeps the second copy waiting
   assign doubled   = is_letter && held_valid_ff && !decrypt_ff && (held_letter_ff == up_byte);

   // the pair always starts with the waiting letter; the partner is either the
   // new letter or the pad of the waiting letter
   assign pair_second = (is_letter && !doubled) ? up_byte : pad_for(held_letter_ff);

   pf6_pair_unit u_pair (
      .square        (square_ff),
      .decrypt       (decrypt_ff),
      .first_letter  (held_letter_ff),
      .second_letter (pair_second),
      .first_out     (pair_out0),
      .second_out    (pair_out1)
   );

   // results of the item in the input register and the next waiting letter
   always_comb begin
      res_byte       = '0;
      res_count      = 2'd0;
      held_valid_in  = held_valid_ff;
      held_letter_in = held_letter_ff;
      if (advance) begin
         if (is_letter) begin
            if (!held_valid_ff) begin
               held_valid_in  = 1'b1;
               held_letter_in = up_byte;
            end else begin
               res_byte[0] = pair_out0;
               res_byte[1] = pair_out1;
               res_count   = 2'd2;
               if (!doubled) begin
                  held_valid_in  = 1'b0;
                  held_letter_in = '0;
               end
            end
         end else begin
            // flush the waiting letter, then pass the byte for text items
            held_valid_in  = 1'b0;
            held_letter_in = '0;
            if (!held_valid_ff) begin
               res_byte[0] = in_item_ff.text_byte;
               res_count   = is_end ? 2'd0 : 2'd1;
            end else if (decrypt_ff) begin
               res_byte[0] = held_letter_ff;
               res_byte[1] = in_item_ff.text_byte;
               res_count   = is_end ? 2'd1 : 2'd2;
            end else begin
               res_byte[0] = pair_out0;
               res_byte[1] = pair_out1;
               res_byte[2] = in_item_ff.text_byte;
               res_count   = is_end ? 2'd2 : 2'd3;
            end
         end
      end
   end

   // result buffer load and drain
   always_comb begin
      rb_byte_in = rb_byte_ff;
      rb_left_in = rb_left_ff;
      rb_pos_in  = rb_pos_ff;
      if (advance) begin
         rb_byte_in = res_byte;
         rb_left_in = res_count;
         rb_pos_in  = 2'd0;
      end else if (rsp_valid && rsp_ready) begin
         rb_left_in = rb_left_ff - 2'd1;
         rb_pos_in  = rb_pos_ff + 2'd1;
      end
   end

   assign rsp_valid         = (rb_left_ff != 2'd0);
   assign rsp_item.out_byte = rb_byte_ff[rb_pos_ff];
   assign rsp_item.last     = (rb_left_ff == 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_ff     <= 1'b0;
         square_ff      <= '0;
         in_valid_ff    <= 1'b0;
         held_valid_ff  <= 1'b0;
         held_letter_ff <= '0;
         rb_left_ff     <= 2'd0;
         rb_pos_ff      <= 2'd0;
      end else begin
         decrypt_ff     <= decrypt_in;
         square_ff      <= square_in;
         in_valid_ff    <= in_valid_in;
         held_valid_ff  <= held_valid_in;
         held_letter_ff <= held_letter_in;
         rb_left_ff     <= rb_left_in;
         rb_pos_ff      <= rb_pos_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      rb_byte_ff <= rb_byte_in;
   end

   // the buffer never reads past its third byte
   `PF6_ASSERT_NOW(a_rb_in_range, clock, reset, rsp_valid,
      ({1'b0, rb_left_ff} + {1'b0, rb_pos_ff}) <= 3'd3, "result buffer overrun")

   // a waiting letter is always an upper-case letter or a digit
   `PF6_ASSERT_NOW(a_held_is_alnum, clock, reset, held_valid_ff,
      is_digit_or_upper(held_letter_ff), "waiting letter is not upper-case alnum")

   // end of text always leaves nothing waiting
   `PF6_ASSERT_NEXT(a_end_clears_held, clock, reset, advance && is_end,
      !held_valid_ff, "end of text left a letter waiting")

   // an encrypt flush at end of text yields exactly one padded pair
   `PF6_ASSERT_NEXT(a_end_flush_pair, clock, reset,
      advance && is_end && held_valid_ff && !decrypt_ff,
      rb_left_ff == 2'd2 && rb_pos_ff == 2'd0, "end of text flush is not one pair")

endmodule

[tb/tb_playfair_6x6_stream_cipher.sv]
// self-checking testbench for the 6x6 playfair stream cipher
`timescale 1ns / 1ps

module tb_playfair_6x6_stream_cipher;
   import pf6_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 9;
   // cycles to let a result-less item finish inside the block
   localparam int SETTLE_CYCLES = 8;
   localparam int FINAL_WAIT_LIMIT = 20000;
   localparam int MAX_PRINTS = 40;
   localparam int RANDOM_ITEMS = 62;
   localparam int SQ_CELLS = SQ_DIM * SQ_DIM;

   // values written to the mode register
   localparam logic [ROW_W-1:0] MODE_ENCRYPT = '0;
   localparam logic [ROW_W-1:0] MODE_DECRYPT = ROW_W'(1);

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_item_type           req_item;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_item_type           rsp_item;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ROW_W-1:0]       csr_data;

   playfair_6x6_stream_cipher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // shadow copy of the cipher: key square, mode and the waiting letter
   logic [ROW_W-1:0]  key_rows [SQ_DIM];
   logic              decrypt_on;
   logic              held_on;
   logic [BYTE_W-1:0] held_char;

   // bytes produced by the item being predicted (never more than three)
   rsp_item_type cipher_bytes [3];
   int           cipher_count;

   // cipher bytes still owed by the block, oldest first
   rsp_item_type awaited_bytes [$];
   rsp_item_type wanted_byte;

   // square contents the stimulus draws its letters from
   logic [BYTE_W-1:0] square_chars [SQ_CELLS];
   logic [BYTE_W-1:0] last_char;

   int send_idle_pct = 21;
   int recv_idle_pct = 74;
   int items_taken   = 0;
   int bytes_checked = 0;
   int squares_loaded = 0;
   int error_count   = 0;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   function automatic logic is_text_char(input logic [BYTE_W-1:0] b);
      return b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
   endfunction

   function automatic logic [BYTE_W-1:0] fold_upper(input logic [BYTE_W-1:0] b);
      return (b >= 8'h61 && b <= 8'h7a) ? b - 8'h20 : b;
   endfunction

   // filler letter for a doubled or lone letter: x, or q when the letter is x
   function automatic logic [BYTE_W-1:0] filler_of(input logic [BYTE_W-1:0] b);
      return (b == CHAR_X) ? CHAR_Q : CHAR_X;
   endfunction

   function automatic logic [BYTE_W-1:0] cell_of(input int r, input int c);
      return key_rows[r][BYTE_W*c +: BYTE_W];
   endfunction

   // first matching cell in row-major order wins on duplicates
   function automatic logic find_cell(input logic [BYTE_W-1:0] ch,
                                      output int r, output int c);
      logic hit;
      hit = 1'b0;
      r = 0;
      c = 0;
      for (int i = 0; i < SQ_DIM; i++)
         for (int j = 0; j < SQ_DIM; j++)
            if (!hit && cell_of(i, j) == ch) begin
               hit = 1'b1;
               r = i;
               c = j;
            end
      return hit;
   endfunction

   function automatic void add_cipher_byte(input logic [BYTE_W-1:0] b);
      if (cipher_count < 3) begin
         cipher_bytes[cipher_count] = '{out_byte: b, last: 1'b0};
         cipher_count++;
      end
   endfunction

   // playfair rules on one pair; right/down to encrypt, left/up to decrypt
   function automatic void cipher_pair(input logic [BYTE_W-1:0] a,
                                       input logic [BYTE_W-1:0] b);
      int r1, c1, r2, c2, step;
      logic found_a, found_b;
      step = decrypt_on ? SQ_DIM - 1 : 1;
      found_a = find_cell(a, r1, c1);
      found_b = find_cell(b, r2, c2);
      if (!found_a || !found_b) begin
         // a letter missing from the square leaves the pair as it is
         add_cipher_byte(a);
         add_cipher_byte(b);
      end else if (r1 == r2) begin
         add_cipher_byte(cell_of(r1, (c1 + step) % SQ_DIM));
         add_cipher_byte(cell_of(r2, (c2 + step) % SQ_DIM));
      end else if (c1 == c2) begin
         add_cipher_byte(cell_of((r1 + step) % SQ_DIM, c1));
         add_cipher_byte(cell_of((r2 + step) % SQ_DIM, c2));
      end else begin
         add_cipher_byte(cell_of(r1, c2));
         add_cipher_byte(cell_of(r2, c1));
      end
   endfunction

   // a waiting letter is padded when encrypting, sent bare when decrypting
   function automatic void flush_held();
      if (held_on) begin
         if (decrypt_on)
            add_cipher_byte(held_char);
         else
            cipher_pair(held_char, filler_of(held_char));
         held_on   = 1'b0;
         held_char = '0;
      end
   endfunction

   function automatic void predict_item(input req_item_type it);
      logic [BYTE_W-1:0] up;
      cipher_count = 0;
      up = fold_upper(it.text_byte);
      if (it.kind == KIND_END) begin
         flush_held();
      end else if (is_text_char(it.text_byte)) begin
         if (!held_on) begin
            held_on   = 1'b1;
            held_char = up;
         end else if (!decrypt_on && held_char == up) begin
            // doubled letter: pad it, the second copy keeps waiting
            cipher_pair(up, filler_of(up));
         end else begin
            cipher_pair(held_char, up);
            held_on   = 1'b0;
            held_char = '0;
         end
      end else begin
         // formatting and high bytes flush first, then pass through
         flush_held();
         add_cipher_byte(it.text_byte);
      end
      for (int k = 0; k < cipher_count; k++) begin
         if (k == cipher_count - 1) cipher_bytes[k].last = 1'b1;
         awaited_bytes.push_back(cipher_bytes[k]);
      end
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   // one process sees every handshake, so register writes, predictions
   // and checks of the same edge are always applied in this order
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DECRYPT_MODE)
               decrypt_on = csr_data[0];
            else if (csr_index >= CSR_SQUARE_ROW_0 && csr_index <= CSR_SQUARE_ROW_5)
               key_rows[csr_index - CSR_SQUARE_ROW_0] = csr_data;
         end
         if (req_valid && req_ready) begin
            predict_item(req_item);
            items_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b",
                                         rsp_item.out_byte, rsp_item.last));
            end else begin
               wanted_byte = awaited_bytes.pop_front();
               if (rsp_item.out_byte !== wanted_byte.out_byte)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_item.out_byte, wanted_byte.out_byte));
               if (rsp_item.last !== wanted_byte.last)
                  report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                            rsp_item.last, wanted_byte.last,
                                            wanted_byte.out_byte));
               bytes_checked++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------

   // result side stalls at random, re-decided every cycle
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // valid stays up after acceptance until the next falling edge decides
   task automatic send_item(input req_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_item  = it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      req_item_type it;
      it.kind      = KIND_TEXT;
      it.text_byte = b;
      send_item(it);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // text byte is don't-care on end of text, so it gets noise
   task automatic send_end();
      req_item_type it;
      it.kind      = KIND_END;
      it.text_byte = BYTE_W'($urandom_range(255));
      send_item(it);
   endtask

   // stop sending and wait until the block owes nothing
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [ROW_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_square();
      logic [ROW_W-1:0] row;
      for (int r = 0; r < SQ_DIM; r++) begin
         for (int c = 0; c < SQ_DIM; c++)
            row[BYTE_W*c +: BYTE_W] = square_chars[r*SQ_DIM + c];
         write_reg(CSR_INDEX_W'(CSR_SQUARE_ROW_0 + r), row);
      end
      squares_loaded++;
   endtask

   // same raw value in all six rows, for the register extremes
   task automatic write_uniform_rows(input logic [ROW_W-1:0] val);
      for (int r = 0; r < SQ_DIM; r++)
         write_reg(CSR_INDEX_W'(CSR_SQUARE_ROW_0 + r), val);
      squares_loaded++;
   endtask

   function automatic void set_standard_chars();
      string alphabet;
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
      for (int i = 0; i < SQ_CELLS; i++) square_chars[i] = alphabet[i];
   endfunction

   function automatic void shuffle_chars();
      logic [BYTE_W-1:0] t;
      int j;
      for (int i = SQ_CELLS - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = square_chars[i];
         square_chars[i] = square_chars[j];
         square_chars[j] = t;
      end
   endfunction

   // mostly letters of the loaded square in mixed case, with doubled
   // letters, formatting bytes, raw bytes and end-of-text thrown in
   function automatic req_item_type random_item();
      req_item_type it;
      logic [BYTE_W-1:0] ch;
      int pick;
      string punct;
      punct = " .,;-!?\n";
      pick = $urandom_range(99);
      it.kind = KIND_TEXT;
      if (pick < 72) begin
         if (pick < 14 && last_char != 0)
            ch = last_char;
         else
            ch = square_chars[$urandom_range(SQ_CELLS - 1)];
         last_char = ch;
         if (ch >= "A" && ch <= "Z" && $urandom_range(1)) ch = ch + 8'h20;
         it.text_byte = ch;
      end else if (pick < 86) begin
         it.text_byte = punct[$urandom_range(punct.len() - 1)];
      end else if (pick < 94) begin
         it.text_byte = BYTE_W'($urandom_range(255));
      end else begin
         it.kind = KIND_END;
         it.text_byte = BYTE_W'($urandom_range(255));
      end
      return it;
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // standard square: rows ABCDEF GHIJKL MNOPQR STUVWX YZ0123 456789
   task automatic test_encrypt_rules();
      wait_drained();
      write_reg(CSR_DECRYPT_MODE, MODE_ENCRYPT);
      set_standard_chars();
      write_square();
      send_text("Hi");      // lower case, same-row rule
      send_text("aaB");     // doubled letter padded with x, second a pairs with b
      send_text("xx ");     // doubled x padded with q, then flush and pass: three bytes
      send_text("94");      // same row, wraps past the last column
      send_text("5B");      // same column, wraps past the last row
      send_text("z");
      send_byte(8'hff);     // high byte flushes the waiting letter
      send_end();           // end of text with nothing waiting
      send_text("{");       // just past the lower-case range
   endtask

   task automatic test_decrypt_rules();
      wait_drained();
      write_reg(CSR_DECRYPT_MODE, MODE_DECRYPT);
      send_text("AA");      // doubled pair takes the same-row rule
      send_text("Q");
      send_end();           // lone letter goes out bare
      send_text("7");
      send_byte(8'h00);     // flush before a zero byte
   endtask

   task automatic test_irregular_squares();
      wait_drained();
      write_reg(CSR_DECRYPT_MODE, MODE_ENCRYPT);
      // last cell overwritten: 9 is missing and A appears twice
      set_standard_chars();
      square_chars[SQ_CELLS - 1] = "A";
      write_square();
      send_text("9C");      // missing letter leaves the pair unchanged
      send_text("AF");      // first A is the one at row 0
      wait_drained();
      write_uniform_rows({ROW_W{1'b1}});
      send_text("ab");
      wait_drained();
      write_uniform_rows('0);
      send_text("c");
      send_end();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic [ROW_W-1:0] mode);
      wait_drained();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_reg(CSR_DECRYPT_MODE, mode);
      set_standard_chars();
      shuffle_chars();
      write_square();
      last_char = '0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // hold off once midway until everything owed has come back
         if (i == RANDOM_ITEMS / 2) wait_drained();
         send_item(random_item());
      end
      send_end();
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      for (int r = 0; r < SQ_DIM; r++) key_rows[r] = '0;
      decrypt_on = 1'b0;
      held_on    = 1'b0;
      held_char  = '0;
      last_char  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_encrypt_rules();
      test_decrypt_rules();
      test_irregular_squares();
      test_random_traffic(21, 74, MODE_ENCRYPT);
      test_random_traffic(74, 21, MODE_DECRYPT);
      test_random_traffic(0, 0, $urandom_range(1) ? MODE_DECRYPT : MODE_ENCRYPT);

      // final drain, bounded so a missing byte shows up as a mismatch
      @(negedge clock);
      req_valid = 1'b0;
      for (int w = 0; w < FINAL_WAIT_LIMIT && awaited_bytes.size() != 0; w++)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (awaited_bytes.size() != 0)
         report_mismatch($sformatf("%0d cipher bytes never arrived", awaited_bytes.size()));

      $display("run: %0d items in, %0d cipher bytes checked, %0d square loads",
               items_taken, bytes_checked, squares_loaded);
      $display("run: encrypt and decrypt, padding, wraps, odd squares, %0d mismatches",
               error_count);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog, far above the slowest correct run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
